FILE: rtl/core/cpfc_pkg.sv
// Shared types and constants for the cursor pixel format converter.
`timescale 1ns / 1ps
`default_nettype none

package cpfc_pkg;

  localparam int unsigned MAX_W   = 16;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned BPP_W   = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED_MAX        = 3'd0,
    CFG_GREEN_MAX      = 3'd1,
    CFG_BLUE_MAX       = 3'd2,
    CFG_RED_SHIFT      = 3'd3,
    CFG_GREEN_SHIFT    = 3'd4,
    CFG_BLUE_SHIFT     = 3'd5,
    CFG_BITS_PER_PIXEL = 3'd6,
    CFG_BIG_ENDIAN     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [MAX_W-1:0]   red_max;
    logic [MAX_W-1:0]   green_max;
    logic [MAX_W-1:0]   blue_max;
    logic [SHIFT_W-1:0] red_shift;
    logic [SHIFT_W-1:0] green_shift;
    logic [SHIFT_W-1:0] blue_shift;
    logic [BPP_W-1:0]   bits_per_pixel;
    logic               big_endian;
  } cfg_t;

  typedef struct packed {
    logic [7:0] mask_byte;
    logic       mask_valid;
  } mask_res_t;

  localparam logic [7:0] ALPHA_LIMIT = 8'd25;
  localparam logic [7:0] MASK_MSB    = 8'h80;
  localparam logic [2:0] LAST_PHASE  = 3'd7;

  localparam logic [2:0] BYTES_NONE = 3'd0;
  localparam logic [2:0] BYTES_ONE  = 3'd1;
  localparam logic [2:0] BYTES_TWO  = 3'd2;
  localparam logic [2:0] BYTES_FOUR = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/core/cpfc_stream_if.sv
// Valid/ready stream interfaces for the pixel beats and the result beats.
`timescale 1ns / 1ps
`default_nettype none

interface cpfc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] alpha_in;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       last_in_row;

  modport source (output valid, alpha_in, red_in, green_in, blue_in, last_in_row,
                  input ready);
  modport sink (input valid, alpha_in, red_in, green_in, blue_in, last_in_row,
                output ready);
endinterface

interface cpfc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic [2:0]  pixel_bytes;
  logic [7:0]  mask_byte;
  logic        mask_valid;

  modport source (output valid, pixel_word, pixel_bytes, mask_byte, mask_valid,
                  input ready);
  modport sink (input valid, pixel_word, pixel_bytes, mask_byte, mask_valid,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cpfc_cfg_regs.sv
// Configuration register file with the client pixel format settings.
`timescale 1ns / 1ps
`default_nettype none

module cpfc_cfg_regs
  import cpfc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RED_MAX:        cfg_nxt.red_max        = cfg_data;
        CFG_GREEN_MAX:      cfg_nxt.green_max      = cfg_data;
        CFG_BLUE_MAX:       cfg_nxt.blue_max       = cfg_data;
        CFG_RED_SHIFT:      cfg_nxt.red_shift      = cfg_data[SHIFT_W-1:0];
        CFG_GREEN_SHIFT:    cfg_nxt.green_shift    = cfg_data[SHIFT_W-1:0];
        CFG_BLUE_SHIFT:     cfg_nxt.blue_shift     = cfg_data[SHIFT_W-1:0];
        CFG_BITS_PER_PIXEL: cfg_nxt.bits_per_pixel = cfg_data[BPP_W-1:0];
        CFG_BIG_ENDIAN:     cfg_nxt.big_endian     = cfg_data[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_max        <= 16'd255;
      cfg_r.green_max      <= 16'd255;
      cfg_r.blue_max       <= 16'd255;
      cfg_r.red_shift      <= 5'd16;
      cfg_r.green_shift    <= 5'd8;
      cfg_r.blue_shift     <= 5'd0;
      cfg_r.bits_per_pixel <= 6'd32;
      cfg_r.big_endian     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/core/cpfc_pack.sv
// Component reduction, placement, size cut and byte ordering of one pixel.
`timescale 1ns / 1ps
`default_nettype none

module cpfc_pack
  import cpfc_pkg::*;
(
  input  wire cfg_t         cfg,
  input  wire logic [7:0]   red_in,
  input  wire logic [7:0]   green_in,
  input  wire logic [7:0]   blue_in,
  output logic      [31:0]  pixel_word,
  output logic      [2:0]   pixel_bytes
);

  // The right shift is 8 minus ceil(log2(max)), never below zero.
  function automatic logic [3:0] reduce_amount(input logic [MAX_W-1:0] max);
    logic [3:0] amount;
    amount = 4'd8;
    for (int k = 0; k < 8; k++) begin
      if (max > MAX_W'(1 << k)) begin
        amount = 4'(7 - k);
      end
    end
    return amount;
  endfunction

  function automatic logic [31:0] place(input logic [7:0] comp,
                                        input logic [MAX_W-1:0] max,
                                        input logic [SHIFT_W-1:0] pos);
    logic [7:0]  v;
    logic [39:0] wide;
    v    = comp >> reduce_amount(max);
    wide = {32'd0, v} << pos;
    return wide[31:0];
  endfunction

  logic [31:0] packed_word;
  logic [6:0]  size_sum;
  logic [3:0]  size;

  always_comb begin
    packed_word = place(red_in, cfg.red_max, cfg.red_shift)
                | place(green_in, cfg.green_max, cfg.green_shift)
                | place(blue_in, cfg.blue_max, cfg.blue_shift);
    size_sum    = {1'b0, cfg.bits_per_pixel} + 7'd7;
    size        = size_sum[6:3];
    pixel_word  = 32'd0;
    pixel_bytes = BYTES_NONE;
    unique case (size)
      4'd1: begin
        pixel_word  = {24'd0, packed_word[7:0]};
        pixel_bytes = BYTES_ONE;
      end
      4'd2: begin
        pixel_word  = cfg.big_endian ? {16'd0, packed_word[15:0]}
                                     : {16'd0, packed_word[7:0], packed_word[15:8]};
        pixel_bytes = BYTES_TWO;
      end
      4'd4: begin
        pixel_word  = cfg.big_endian ? packed_word
                                     : {packed_word[7:0], packed_word[15:8],
                                        packed_word[23:16], packed_word[31:24]};
        pixel_bytes = BYTES_FOUR;
      end
      default: begin
        pixel_word  = 32'd0;
        pixel_bytes = BYTES_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/cpfc_mask.sv
// Visibility mask builder that closes a byte after eight pixels or a row end.
`timescale 1ns / 1ps
`default_nettype none

module cpfc_mask
  import cpfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       advance,
  input  wire logic [7:0] alpha_in,
  input  wire logic       last_in_row,
  output mask_res_t       res
);

  logic [2:0] phase_r;
  logic [2:0] phase_nxt;
  logic [7:0] acc_r;
  logic [7:0] acc_nxt;
  logic [7:0] acc_set;
  logic       close;

  always_comb begin
    acc_set = acc_r;
    if (alpha_in > ALPHA_LIMIT) begin
      acc_set = acc_r | (MASK_MSB >> phase_r);
    end
    close = (phase_r == LAST_PHASE) || last_in_row;
    res.mask_valid = close;
    res.mask_byte  = close ? acc_set : 8'd0;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    if (advance) begin
      phase_nxt = close ? 3'd0 : phase_r + 3'd1;
      acc_nxt   = close ? 8'd0 : acc_set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 3'd0;
      acc_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cursor_pixel_format_converter.sv
// Top level of the cursor pixel format converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts one 8-bit ARGB cursor pixel per beat into the configured client
// pixel format and builds the one-bit-per-pixel visibility mask alongside it.
// Every pixel beat yields exactly one result beat. The block takes one beat
// per clock cycle while the result side is not stalled and registers it first
// in the input register and then in the result register; both stages
// hold their contents while the result side stalls. Configuration writes
// must only be issued while no beat is in flight.

module cursor_pixel_format_converter
  import cpfc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  cpfc_pix_if.sink                   in_chan,
  cpfc_res_if.source                 out_chan
);

  cfg_t      cfg;
  mask_res_t mask_res;

  logic        s1_valid_r;
  logic [7:0]  s1_alpha_r;
  logic [7:0]  s1_red_r;
  logic [7:0]  s1_green_r;
  logic [7:0]  s1_blue_r;
  logic        s1_last_r;

  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_bytes_r;
  logic [7:0]  out_mask_r;
  logic        out_mvalid_r;

  logic [31:0] pixel_word;
  logic [2:0]  pixel_bytes;
  logic        out_free;
  logic        s1_move;
  logic        in_take;

  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_take  = in_chan.valid && in_chan.ready;

  assign in_chan.ready = !s1_valid_r || out_free;

  cpfc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cpfc_pack u_pack (
    .cfg         (cfg),
    .red_in      (s1_red_r),
    .green_in    (s1_green_r),
    .blue_in     (s1_blue_r),
    .pixel_word  (pixel_word),
    .pixel_bytes (pixel_bytes)
  );

  cpfc_mask u_mask (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (s1_move),
    .alpha_in    (s1_alpha_r),
    .last_in_row (s1_last_r),
    .res         (mask_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_alpha_r <= in_chan.alpha_in;
      s1_red_r   <= in_chan.red_in;
      s1_green_r <= in_chan.green_in;
      s1_blue_r  <= in_chan.blue_in;
      s1_last_r  <= in_chan.last_in_row;
    end
    if (s1_move) begin
      out_word_r   <= pixel_word;
      out_bytes_r  <= pixel_bytes;
      out_mask_r   <= mask_res.mask_byte;
      out_mvalid_r <= mask_res.mask_valid;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_word  = out_word_r;
  assign out_chan.pixel_bytes = out_bytes_r;
  assign out_chan.mask_byte   = out_mask_r;
  assign out_chan.mask_valid  = out_mvalid_r;

endmodule

`default_nettype wire

FILE: test/cursor_pixel_format_converter_test.sv
// Self-checking testbench for the cursor pixel format converter: pixel stream, formats, mask.
`timescale 1ns / 1ps

module cursor_pixel_format_converter_test;
  import cpfc_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 1000;
  localparam int unsigned FORMAT_PHASES = 16;
  localparam int unsigned PHASE_PIXELS  = 88;

  typedef struct {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  bytes;
    logic [7:0]  mask_byte;
    logic        mask_valid;
  } converted_t;

  class cursor_format_predictor;
    cfg_t         fmt;
    logic [2:0]   column;
    logic [7:0]   mask_acc;
    converted_t   pending_results[$];
    int unsigned  errors;
    int unsigned  pixels;
    int unsigned  mask_bytes;
    int unsigned  unsupported;

    function new();
      fmt.red_max        = 16'd255;
      fmt.green_max      = 16'd255;
      fmt.blue_max       = 16'd255;
      fmt.red_shift      = 5'd16;
      fmt.green_shift    = 5'd8;
      fmt.blue_shift     = 5'd0;
      fmt.bits_per_pixel = 6'd32;
      fmt.big_endian     = 1'b1;
      column             = 3'd0;
      mask_acc           = 8'd0;
      errors             = 0;
      pixels             = 0;
      mask_bytes         = 0;
      unsupported        = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_RED_MAX:        fmt.red_max        = data;
        CFG_GREEN_MAX:      fmt.green_max      = data;
        CFG_BLUE_MAX:       fmt.blue_max       = data;
        CFG_RED_SHIFT:      fmt.red_shift      = data[SHIFT_W-1:0];
        CFG_GREEN_SHIFT:    fmt.green_shift    = data[SHIFT_W-1:0];
        CFG_BLUE_SHIFT:     fmt.blue_shift     = data[SHIFT_W-1:0];
        CFG_BITS_PER_PIXEL: fmt.bits_per_pixel = data[BPP_W-1:0];
        CFG_BIG_ENDIAN:     fmt.big_endian     = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned drop_bits(logic [MAX_W-1:0] top);
      int unsigned amount;
      int unsigned reach;
      amount = 8;
      reach  = 1;
      while (reach < top && amount > 0) begin
        reach = reach << 1;
        amount--;
      end
      return amount;
    endfunction

    function logic [31:0] place(logic [7:0] c, logic [MAX_W-1:0] top, logic [SHIFT_W-1:0] pos);
      logic [31:0] v;
      v = {24'd0, c} >> drop_bits(top);
      return v << pos;
    endfunction

    function void take_pixel(pixel_t p);
      converted_t  r;
      logic [31:0] packed_word;
      int unsigned size;
      packed_word = place(p.red, fmt.red_max, fmt.red_shift)
                  | place(p.green, fmt.green_max, fmt.green_shift)
                  | place(p.blue, fmt.blue_max, fmt.blue_shift);
      size = (int'(fmt.bits_per_pixel) + 7) / 8;
      r.word  = 32'd0;
      r.bytes = BYTES_NONE;
      if (size == 1) begin
        r.word  = {24'd0, packed_word[7:0]};
        r.bytes = BYTES_ONE;
      end else if (size == 2) begin
        r.word  = fmt.big_endian ? {16'd0, packed_word[15:0]}
                                 : {16'd0, packed_word[7:0], packed_word[15:8]};
        r.bytes = BYTES_TWO;
      end else if (size == 4) begin
        r.word  = fmt.big_endian ? packed_word
                                 : {packed_word[7:0], packed_word[15:8],
                                    packed_word[23:16], packed_word[31:24]};
        r.bytes = BYTES_FOUR;
      end else begin
        unsupported++;
      end
      if (p.alpha > ALPHA_LIMIT) mask_acc = mask_acc | (MASK_MSB >> column);
      r.mask_byte  = 8'd0;
      r.mask_valid = 1'b0;
      if (column == LAST_PHASE || p.last) begin
        r.mask_byte  = mask_acc;
        r.mask_valid = 1'b1;
        mask_acc     = 8'd0;
        column       = 3'd0;
        mask_bytes++;
      end else begin
        column = column + 3'd1;
      end
      pixels++;
      pending_results.push_back(r);
    endfunction

    function void check_result(converted_t got);
      converted_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no pixel outstanding: word %h", got.word);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.word !== want.word) begin
        $error("pixel_word mismatch: expected %h, actual %h", want.word, got.word);
        errors++;
      end
      if (got.bytes !== want.bytes) begin
        $error("pixel_bytes mismatch: expected %0d, actual %0d", want.bytes, got.bytes);
        errors++;
      end
      if (got.mask_byte !== want.mask_byte) begin
        $error("mask_byte mismatch: expected %h, actual %h", want.mask_byte, got.mask_byte);
        errors++;
      end
      if (got.mask_valid !== want.mask_valid) begin
        $error("mask_valid mismatch: expected %b, actual %b", want.mask_valid, got.mask_valid);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void report_leftover();
      if (pending_results.size() != 0) begin
        $error("%0d result beats never arrived", pending_results.size());
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cpfc_pix_if pix_chan();
  cpfc_res_if res_chan();

  cursor_pixel_format_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (pix_chan),
    .out_chan (res_chan)
  );

  cursor_format_predictor predictor;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    res_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    converted_t got;
    pixel_t     p;
    if (rst_n) begin
      if (pix_chan.valid && pix_chan.ready) begin
        p.alpha = pix_chan.alpha_in;
        p.red   = pix_chan.red_in;
        p.green = pix_chan.green_in;
        p.blue  = pix_chan.blue_in;
        p.last  = pix_chan.last_in_row;
        predictor.take_pixel(p);
      end
      if (res_chan.valid && res_chan.ready) begin
        got.word       = res_chan.pixel_word;
        got.bytes      = res_chan.pixel_bytes;
        got.mask_byte  = res_chan.mask_byte;
        got.mask_valid = res_chan.mask_valid;
        predictor.check_result(got);
      end
    end
    if ((pix_chan.valid && pix_chan.ready) || (res_chan.valid && res_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout after %0d cycles without a beat", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic pixel_t make_pixel(logic [7:0] a, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b, logic l);
    pixel_t p;
    p.alpha = a;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.last  = l;
    return p;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.alpha = ($urandom_range(3) == 0) ? 8'($urandom_range(20, 31)) : 8'($urandom);
    p.red   = 8'($urandom);
    p.green = 8'($urandom);
    p.blue  = 8'($urandom);
    p.last  = ($urandom_range(5) == 0);
    return p;
  endfunction

  function automatic logic [MAX_W-1:0] random_max();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'($urandom_range(2, 16));
      3: return 16'($urandom_range(17, 255));
      4: return 16'($urandom_range(256, 512));
      5: return 16'($urandom);
      6: return 16'hFFFF;
      default: return 16'd255;
    endcase
  endfunction

  function automatic cfg_t pick_format(int unsigned phase);
    cfg_t f;
    f.red_max        = random_max();
    f.green_max      = random_max();
    f.blue_max       = random_max();
    f.red_shift      = 5'($urandom);
    f.green_shift    = 5'($urandom);
    f.blue_shift     = 5'($urandom);
    f.big_endian     = 1'($urandom);
    case ($urandom_range(3))
      0: f.bits_per_pixel = 6'($urandom);
      1: f.bits_per_pixel = 6'd16;
      2: f.bits_per_pixel = 6'd32;
      default: f.bits_per_pixel = 6'($urandom_range(1, 8));
    endcase
    case (phase)
      0: f = '{16'd0, 16'd1, 16'd0, 5'd0, 5'd0, 5'd0, 6'd8, 1'b0};
      1: f = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 5'd31, 5'd31, 6'd32, 1'b0};
      2: f = '{16'd31, 16'd63, 16'd31, 5'd11, 5'd5, 5'd0, 6'd16, 1'b0};
      3: f = '{16'd31, 16'd63, 16'd31, 5'd11, 5'd5, 5'd0, 6'd16, 1'b1};
      4: f = '{16'd255, 16'd255, 16'd255, 5'd16, 5'd8, 5'd0, 6'd24, 1'b1};
      5: f = '{16'd256, 16'd257, 16'd512, 5'd30, 5'd20, 5'd25, 6'd0, 1'b0};
      6: f = '{16'd7, 16'd7, 16'd3, 5'd5, 5'd2, 5'd0, 6'd1, 1'b1};
      7: f = '{16'd1023, 16'd2, 16'd3, 5'd20, 5'd10, 5'd0, 6'd63, 1'b0};
      8: f = '{16'd255, 16'd255, 16'd255, 5'd24, 5'd16, 5'd8, 6'd25, 1'b0};
      default: ;
    endcase
    return f;
  endfunction

  task automatic send_pixel(pixel_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      pix_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    pix_chan.valid       <= 1'b1;
    pix_chan.alpha_in    <= p.alpha;
    pix_chan.red_in      <= p.red;
    pix_chan.green_in    <= p.green;
    pix_chan.blue_in     <= p.blue;
    pix_chan.last_in_row <= p.last;
    do @(posedge clk); while (!pix_chan.ready);
  endtask

  task automatic settle();
    pix_chan.valid <= 1'b0;
    do @(posedge clk); while (predictor.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_format(cfg_t f);
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] val;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_t'(i);
      case (idx)
        CFG_RED_MAX:        val = f.red_max;
        CFG_GREEN_MAX:      val = f.green_max;
        CFG_BLUE_MAX:       val = f.blue_max;
        CFG_RED_SHIFT:      val = 16'(f.red_shift);
        CFG_GREEN_SHIFT:    val = 16'(f.green_shift);
        CFG_BLUE_SHIFT:     val = 16'(f.blue_shift);
        CFG_BITS_PER_PIXEL: val = 16'(f.bits_per_pixel);
        default:            val = 16'(f.big_endian);
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
      predictor.write_reg(idx, val);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd25, 8'h80, 8'h7F, 8'h01, 1'b0));
    send_pixel(make_pixel(8'd26, 8'h55, 8'hAA, 8'hF0, 1'b0));
    send_pixel(make_pixel(8'd24, 8'h0F, 8'hF0, 8'h3C, 1'b0));
    send_pixel(make_pixel(8'd127, 8'hFE, 8'h01, 8'h80, 1'b0));
    send_pixel(make_pixel(8'd0, 8'h12, 8'h34, 8'h56, 1'b0));
    send_pixel(make_pixel(8'd200, 8'hC3, 8'h3C, 8'h99, 1'b0));
    send_pixel(make_pixel(8'd255, 8'h01, 8'h02, 8'h04, 1'b1));
    send_pixel(make_pixel(8'd10, 8'hFF, 8'h00, 8'hFF, 1'b1));
    for (int i = 0; i < 4; i++)
      send_pixel(make_pixel(i[0] ? 8'd26 : 8'd25, 8'(i * 37), 8'(i * 91), 8'(i * 13),
                            i == 3));
    for (int i = 0; i < 8; i++)
      send_pixel(make_pixel(i[1] ? 8'd255 : 8'd3, 8'(255 - i), 8'(i), 8'(i * 32),
                            i == 7));
  endtask

  initial begin
    predictor = new();
    quiet_cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_RED_MAX;
    cfg_data             <= '0;
    pix_chan.valid       <= 1'b0;
    pix_chan.alpha_in    <= 8'd0;
    pix_chan.red_in      <= 8'd0;
    pix_chan.green_in    <= 8'd0;
    pix_chan.blue_in     <= 8'd0;
    pix_chan.last_in_row <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    settle();
    for (int unsigned phase = 0; phase < FORMAT_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      load_format(pick_format(phase));
      repeat (PHASE_PIXELS) send_pixel(random_pixel());
      settle();
    end
    repeat (8) @(posedge clk);
    predictor.report_leftover();
    $display("Checked %0d pixel beats under %0d client formats and four idle patterns.",
             predictor.pixels, FORMAT_PHASES + 1);
    $display("Mask bytes flushed: %0d; pixels of unsupported size: %0d.",
             predictor.mask_bytes, predictor.unsupported);
    if (predictor.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cpfc_pkg.sv
rtl/core/cpfc_stream_if.sv
rtl/core/cpfc_cfg_regs.sv
rtl/core/cpfc_pack.sv
rtl/core/cpfc_mask.sv
rtl/core/cursor_pixel_format_converter.sv
test/cursor_pixel_format_converter_test.sv
